@@ src/spl_pkg.sv @@
// Shared types and constants for the symbol predecessor lookup unit.
`default_nettype none

package spl_pkg;

	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned NAME_W  = 16;
	localparam int unsigned ENTRY_W = ADDR_W + NAME_W;

	localparam logic [ADDR_W-1:0] MAX_OFFSET_RESET = 32'h0010_0000;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_NONE = 2'd1,
		STAT_FAR  = 2'd2,
		STAT_FULL = 2'd3
	} status_t;

	// Which result the datapath registers on an emit command
	typedef enum logic [1:0] {
		RES_OK     = 2'd0,
		RES_NONE   = 2'd1,
		RES_FULL   = 2'd2,
		RES_LOOKUP = 2'd3
	} res_kind_t;

	typedef enum logic [1:0] {
		FSM_IDLE   = 2'd0,
		FSM_SCAN   = 2'd1,
		FSM_DRAIN  = 2'd2,
		FSM_FINISH = 2'd3
	} fsm_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic      clr;
		logic      wr_en;
		logic      load_key;
		logic      rd_en;
		logic      emit;
		res_kind_t res;
	} spl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic cnt_zero;
		logic full;
		logic scan_last;
	} spl_sts_t;

endpackage

`default_nettype wire

@@ src/spl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module spl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                                          clk,
	input  wire logic                                          we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                              wdata,
	input  wire logic                                          re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ src/spl_ctrl.sv @@
// Controller state machine: sequences insert, clear and the lookup scan.
`default_nettype none

module spl_ctrl
	import spl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] op,
	input  wire spl_sts_t   sts,
	output spl_cmd_t        cmd,
	output logic            busy
);

	fsm_state_t state_q;
	fsm_state_t state_nxt;
	op_t        op_in;

	assign op_in = op_t'(op);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt    = state_q;
		cmd          = '0;
		cmd.res      = RES_OK;
		busy         = 1'b1;
		case (state_q)
			FSM_IDLE: begin
				busy = 1'b0;
				if (start) begin
					case (op_in)
						OP_CLEAR: begin
							cmd.clr  = 1'b1;
							cmd.emit = 1'b1;
							cmd.res  = RES_OK;
						end
						OP_INSERT: begin
							cmd.emit = 1'b1;
							if (sts.full) begin
								cmd.res = RES_FULL;
							end else begin
								cmd.wr_en = 1'b1;
								cmd.res   = RES_OK;
							end
						end
						OP_LOOKUP: begin
							if (sts.cnt_zero) begin
								cmd.emit = 1'b1;
								cmd.res  = RES_NONE;
							end else begin
								cmd.load_key = 1'b1;
								state_nxt    = FSM_SCAN;
							end
						end
						default: begin
							cmd.emit = 1'b1;
							cmd.res  = RES_OK;
						end
					endcase
				end
			end
			FSM_SCAN: begin
				// Read one entry per cycle until the last stored one
				cmd.rd_en = 1'b1;
				if (sts.scan_last) begin
					state_nxt = FSM_DRAIN;
				end
			end
			FSM_DRAIN: begin
				// Last read beat is compared here
				state_nxt = FSM_FINISH;
			end
			FSM_FINISH: begin
				cmd.emit  = 1'b1;
				cmd.res   = RES_LOOKUP;
				state_nxt = FSM_IDLE;
			end
			default: begin
				state_nxt = FSM_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ src/spl_datapath.sv @@
// Datapath: entry table, fill count, scan compare and result registers.
`default_nettype none

module spl_datapath
	import spl_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire spl_cmd_t          cmd,
	output spl_sts_t               sts,
	input  wire logic [ADDR_W-1:0] address,
	input  wire logic [NAME_W-1:0] name_handle,
	input  wire logic              cfg_we,
	input  wire logic [ADDR_W-1:0] cfg_wdata,
	output logic                   done,
	output logic [1:0]             status,
	output logic [NAME_W-1:0]      found_name,
	output logic [ADDR_W-1:0]      offset
);

	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      idx_q;
	logic [ADDR_W-1:0]  max_off_q;
	logic [ADDR_W-1:0]  key_q;
	logic               found_q;
	logic [ADDR_W-1:0]  best_addr_q;
	logic [NAME_W-1:0]  best_name_q;
	logic               rd_valid_s1;
	logic [ENTRY_W-1:0] rdata_s1;
	logic [ADDR_W-1:0]  ent_addr;
	logic [NAME_W-1:0]  ent_name;
	logic               better;
	logic [ADDR_W-1:0]  diff;

	// Entry table: start address in the upper bits, name handle below
	spl_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (cnt_q[AW-1:0]),
		.wdata ({address, name_handle}),
		.re    (cmd.rd_en),
		.raddr (idx_q[AW-1:0]),
		.rdata (rdata_s1)
	);

	assign sts.cnt_zero  = (cnt_q == '0);
	assign sts.full      = (cnt_q == CW'(TABLE_DEPTH));
	assign sts.scan_last = (idx_q == (cnt_q - CW'(1)));

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_off_q <= MAX_OFFSET_RESET;
		end else if (cfg_we) begin
			max_off_q <= cfg_wdata;
		end
	end

	// Fill count and scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_en;
			if (cmd.clr) begin
				cnt_q <= '0;
			end else if (cmd.wr_en) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.load_key) begin
				idx_q <= '0;
			end else if (cmd.rd_en) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	// Compare the entry read in the previous cycle; later equal entries win
	assign ent_addr = rdata_s1[ENTRY_W-1:NAME_W];
	assign ent_name = rdata_s1[NAME_W-1:0];
	assign better   = (ent_addr <= key_q) && (!found_q || (ent_addr >= best_addr_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.load_key) begin
			found_q <= 1'b0;
		end else if (rd_valid_s1 && better) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_key) begin
			key_q <= address;
		end
		if (rd_valid_s1 && better) begin
			best_addr_q <= ent_addr;
			best_name_q <= ent_name;
		end
	end

	assign diff = key_q - best_addr_q;

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.emit;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			found_name <= '0;
			offset     <= '0;
			case (cmd.res)
				RES_OK:   status <= STAT_OK;
				RES_NONE: status <= STAT_NONE;
				RES_FULL: status <= STAT_FULL;
				RES_LOOKUP: begin
					if (!found_q) begin
						status <= STAT_NONE;
					end else if (diff > max_off_q) begin
						status <= STAT_FAR;
					end else begin
						status     <= STAT_OK;
						found_name <= best_name_q;
						offset     <= diff;
					end
				end
				default: status <= STAT_OK;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ src/symbol_predecessor_lookup_unit.sv @@
// Top level of the symbol predecessor lookup unit.
//
//  Channel  | Handshake           | Payload
//  ---------+---------------------+----------------------------------
//  command  | start / busy        | op, address, name_handle
//  result   | done (one cycle)    | status, found_name, offset
//  config   | cfg_we              | cfg_wdata (max_offset)
//
// Clear, insert and unused ops are handled in IDLE, result strobed on the next cycle.
// Lookup: SCAN walks the entry table through its single read port, one
// entry per cycle; DRAIN compares the last entry and FINISH emits the result.
// Lookup on an empty table answers from IDLE, with done on the next cycle.
// Reset empties the table and loads max_offset with 0x100000; no clearing pass.
// The receiver cannot stall: done is high for exactly one cycle per command.
`default_nettype none

module symbol_predecessor_lookup_unit
	import spl_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        op,
	input  wire logic [ADDR_W-1:0] address,
	input  wire logic [NAME_W-1:0] name_handle,
	input  wire logic              cfg_we,
	input  wire logic [ADDR_W-1:0] cfg_wdata,
	output logic                   done,
	output logic [1:0]             status,
	output logic [NAME_W-1:0]      found_name,
	output logic [ADDR_W-1:0]      offset
);

	spl_cmd_t cmd;
	spl_sts_t sts;

	spl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	spl_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.address     (address),
		.name_handle (name_handle),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.status      (status),
		.found_name  (found_name),
		.offset      (offset)
	);

	// Ending a scan always delivers its result beat
	a_scan_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("scan ended without a result beat");

	// Non-lookup commands answer on the next cycle
	a_short_op_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (op != OP_LOOKUP)) |=> done)
		else $error("short command gave no result beat");

	// Only a successful result carries a name or an offset
	a_zero_unless_found: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != STAT_OK)) |-> ((found_name == '0) && (offset == '0)))
		else $error("payload set on a failed result");

	// Never an insert into a full table, never a scan of an empty one
	a_cmd_guard: assert property (@(posedge clk) disable iff (!arst_n)
		!((cmd.wr_en && sts.full) || (cmd.load_key && sts.cnt_zero)))
		else $error("table command issued against count limits");

endmodule

`default_nettype wire
